### rtl/core/nnc_pkg.sv
// Shared constants, types and state codes of the nearest-neighbour chain clustering block.
`timescale 1ns / 1ps
package nnc_pkg;
    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_BITS = 18;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int THR_W      = 16;
    localparam int THR2_W     = 2 * THR_W;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(500);
    localparam int OUT_IDX_W  = 10;
    localparam int N_CELLS    = 4;

    // Action codes carried by an input transfer.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef struct packed {
        logic                         valid;
        logic                         last;
        logic [IDX_W-1:0]             idx;
        logic                         vis;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_tag;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_EVAL  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;
endpackage

### rtl/core/nnc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/nnc_cell.sv
// One cell of the scan chain: registers a point tag and hands it to the next cell.
`timescale 1ns / 1ps
module nnc_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nnc_pkg::t_tag i_tag,
    output nnc_pkg::t_tag o_tag
);
    logic          r_valid;
    nnc_pkg::t_tag r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tag.valid;
        end
        r_tag <= i_tag;
    end

    always_comb begin
        o_tag       = r_tag;
        o_tag.valid = r_valid;
    end
endmodule

### rtl/core/nnc_dist.sv
// Three-stage squared-distance unit: absolute differences, squares, sum.
`timescale 1ns / 1ps
module nnc_dist (
    input  logic                                  i_clk,
    input  logic signed [nnc_pkg::COORD_BITS-1:0] i_ax,
    input  logic signed [nnc_pkg::COORD_BITS-1:0] i_ay,
    input  logic signed [nnc_pkg::COORD_BITS-1:0] i_bx,
    input  logic signed [nnc_pkg::COORD_BITS-1:0] i_by,
    output logic [nnc_pkg::DIST_W-1:0]            o_dist
);
    logic signed [nnc_pkg::DIFF_W-1:0] ax, ay, bx, by;
    logic [nnc_pkg::DIFF_W-1:0] n_dx, n_dy, r_dx, r_dy;
    logic [nnc_pkg::SQ_W-1:0]   r_sx, r_sy;
    logic [nnc_pkg::DIST_W-1:0] r_sum;

    always_comb begin
        ax   = nnc_pkg::DIFF_W'(i_ax);
        ay   = nnc_pkg::DIFF_W'(i_ay);
        bx   = nnc_pkg::DIFF_W'(i_bx);
        by   = nnc_pkg::DIFF_W'(i_by);
        n_dx = (ax >= bx) ? nnc_pkg::DIFF_W'(ax - bx) : nnc_pkg::DIFF_W'(bx - ax);
        n_dy = (ay >= by) ? nnc_pkg::DIFF_W'(ay - by) : nnc_pkg::DIFF_W'(by - ay);
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_sx  <= nnc_pkg::SQ_W'(r_dx) * nnc_pkg::SQ_W'(r_dx);
        r_sy  <= nnc_pkg::SQ_W'(r_dy) * nnc_pkg::SQ_W'(r_dy);
        r_sum <= nnc_pkg::DIST_W'(r_sx) + nnc_pkg::DIST_W'(r_sy);
    end

    assign o_dist = r_sum;
endmodule

### rtl/core/nearest_neighbor_chain_cluster.sv
// Top level of the nearest-neighbour chain clustering block.
`timescale 1ns / 1ps
// A load is transferred whenever the block is idle. A step that opens a step phase on a
// non-empty set first clears the visited map, one stored point after another. The first
// point of a phase and a step on an exhausted set need no scan; otherwise the point
// memories are read one entry a cycle and the entries pass down a four-cell chain beside
// a three-stage squared-distance unit, so the memory read port sets the rate. The result
// sits in an output register, so the next item may be transferred while the result waits.
module nearest_neighbor_chain_cluster (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_action,
    input  logic signed [nnc_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [nnc_pkg::COORD_BITS-1:0] i_point_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [nnc_pkg::OUT_IDX_W-1:0]         o_point_index,
    output logic                                  o_object_start,
    output logic                                  o_chain_last,
    output logic                                  o_no_point,
    input  logic                                  i_cfg_we,
    input  logic [nnc_pkg::THR_W-1:0]             i_cfg_data
);
    localparam int CW = nnc_pkg::COORD_BITS;
    localparam int IW = nnc_pkg::IDX_W;
    localparam int NW = nnc_pkg::CNT_W;

    nnc_pkg::t_state r_state, n_state;
    logic [NW-1:0] r_count, r_emitted, r_rd_idx, r_clr;
    logic          r_stepping;
    logic [nnc_pkg::THR2_W-1:0] r_thr2;
    logic signed [CW-1:0] r_p0_x, r_p0_y, r_cur_x, r_cur_y, r_best_x, r_best_y;
    logic [IW-1:0] r_best;
    logic [nnc_pkg::DIST_W-1:0] r_best_d;
    logic          r_found;
    logic          r_pend;
    logic [IW-1:0] r_res_idx;
    logic          r_res_start, r_res_last, r_res_none;
    logic          r_out_valid;
    logic [nnc_pkg::OUT_IDX_W-1:0] r_out_idx;
    logic          r_out_start, r_out_last, r_out_none;

    logic in_xfer, out_free, load_we, issue;
    logic [IW-1:0] load_addr, v_waddr;
    logic          v_we, v_wdata, v_rd;
    logic signed [CW-1:0] x_rd, y_rd;
    logic [nnc_pkg::DIST_W-1:0] sq_gap;
    nnc_pkg::t_tag tag_in [nnc_pkg::N_CELLS];
    nnc_pkg::t_tag tag_out [nnc_pkg::N_CELLS];
    nnc_pkg::t_tag cmp;

    assign o_in_stall = (r_state != nnc_pkg::S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign load_we    = in_xfer && (i_action == nnc_pkg::ACT_LOAD) &&
                        (r_stepping || (r_count < NW'(nnc_pkg::MAX_POINTS)));
    assign load_addr  = r_stepping ? '0 : r_count[IW-1:0];
    assign issue      = (r_state == nnc_pkg::S_SCAN) && (r_rd_idx < r_count);

    always_comb begin
        v_we    = 1'b0;
        v_wdata = 1'b1;
        v_waddr = r_best;
        if (r_state == nnc_pkg::S_CLEAR) begin
            v_we    = 1'b1;
            v_wdata = 1'b0;
            v_waddr = r_clr[IW-1:0];
        end else if (r_state == nnc_pkg::S_EVAL) begin
            v_we    = (r_emitted == '0) && (r_count != '0);
            v_waddr = '0;
        end else if (r_state == nnc_pkg::S_FIN) begin
            v_we    = 1'b1;
        end
    end

    nnc_ram #(.WIDTH(CW), .DEPTH(nnc_pkg::MAX_POINTS)) u_x_ram (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(load_addr), .i_wdata(i_point_x),
        .i_raddr(r_rd_idx[IW-1:0]), .o_rdata(x_rd)
    );
    nnc_ram #(.WIDTH(CW), .DEPTH(nnc_pkg::MAX_POINTS)) u_y_ram (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(load_addr), .i_wdata(i_point_y),
        .i_raddr(r_rd_idx[IW-1:0]), .o_rdata(y_rd)
    );
    nnc_ram #(.WIDTH(1), .DEPTH(nnc_pkg::MAX_POINTS)) u_v_ram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(r_rd_idx[IW-1:0]), .o_rdata(v_rd)
    );

    nnc_dist u_dist (
        .i_clk(i_clk), .i_ax(x_rd), .i_ay(y_rd), .i_bx(r_cur_x), .i_by(r_cur_y),
        .o_dist(sq_gap)
    );

    // The first cell runs level with the memory read; the memory data joins the tag at its output.
    always_comb begin
        tag_in[0].valid = issue;
        tag_in[0].last  = (r_rd_idx == r_count - NW'(1));
        tag_in[0].idx   = r_rd_idx[IW-1:0];
        tag_in[0].vis   = 1'b0;
        tag_in[0].x     = '0;
        tag_in[0].y     = '0;
        tag_in[1]       = tag_out[0];
        tag_in[1].vis   = v_rd;
        tag_in[1].x     = x_rd;
        tag_in[1].y     = y_rd;
        for (int k = 2; k < nnc_pkg::N_CELLS; k++) begin
            tag_in[k] = tag_out[k-1];
        end
        cmp = tag_out[nnc_pkg::N_CELLS-1];
    end

    for (genvar g = 0; g < nnc_pkg::N_CELLS; g++) begin : g_cell
        nnc_cell u_cell (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_tag(tag_in[g]), .o_tag(tag_out[g]));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nnc_pkg::S_IDLE: begin
                if (in_xfer && (i_action == nnc_pkg::ACT_STEP)) begin
                    if (!r_stepping && (r_count != '0)) begin
                        n_state = nnc_pkg::S_CLEAR;
                    end else begin
                        n_state = nnc_pkg::S_EVAL;
                    end
                end
            end
            nnc_pkg::S_CLEAR: begin
                if (r_clr == r_count - NW'(1)) begin
                    n_state = nnc_pkg::S_EVAL;
                end
            end
            nnc_pkg::S_EVAL: begin
                // A result already waiting here was made by this step, so no scan follows.
                if (!r_pend && (r_emitted != '0) && (r_emitted < r_count)) begin
                    n_state = nnc_pkg::S_SCAN;
                end else if (out_free) begin
                    n_state = nnc_pkg::S_IDLE;
                end
            end
            nnc_pkg::S_SCAN: begin
                if (cmp.valid && cmp.last) begin
                    n_state = nnc_pkg::S_FIN;
                end
            end
            nnc_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = nnc_pkg::S_IDLE;
                end
            end
            default: n_state = nnc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nnc_pkg::S_IDLE;
            r_count     <= '0;
            r_emitted   <= '0;
            r_stepping  <= 1'b0;
            r_thr2      <= nnc_pkg::THR2_W'(nnc_pkg::THR_RESET) *
                           nnc_pkg::THR2_W'(nnc_pkg::THR_RESET);
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_rd_idx    <= '0;
            r_clr       <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thr2 <= nnc_pkg::THR2_W'(i_cfg_data) * nnc_pkg::THR2_W'(i_cfg_data);
            end
            if (in_xfer && (i_action == nnc_pkg::ACT_LOAD)) begin
                if (r_stepping) begin
                    r_stepping <= 1'b0;
                    r_count    <= NW'(1);
                end else if (r_count < NW'(nnc_pkg::MAX_POINTS)) begin
                    r_count <= r_count + NW'(1);
                end
            end
            if (in_xfer && (i_action == nnc_pkg::ACT_STEP) && !r_stepping) begin
                r_stepping <= 1'b1;
                r_emitted  <= '0;
                r_clr      <= '0;
            end
            if (r_state == nnc_pkg::S_CLEAR) begin
                r_clr <= r_clr + NW'(1);
            end
            if (r_state == nnc_pkg::S_EVAL) begin
                r_rd_idx <= '0;
                r_found  <= 1'b0;
                if (!r_pend && (r_emitted >= r_count)) begin
                    r_pend      <= 1'b1;
                    r_res_idx   <= '0;
                    r_res_start <= 1'b0;
                    r_res_last  <= 1'b0;
                    r_res_none  <= 1'b1;
                end else if (!r_pend && (r_emitted == '0)) begin
                    r_pend      <= 1'b1;
                    r_res_idx   <= '0;
                    r_res_start <= 1'b1;
                    r_res_last  <= (r_count == NW'(1));
                    r_res_none  <= 1'b0;
                    r_emitted   <= NW'(1);
                    r_cur_x     <= r_p0_x;
                    r_cur_y     <= r_p0_y;
                end
            end
            if (issue) begin
                r_rd_idx <= r_rd_idx + NW'(1);
            end
            if ((r_state == nnc_pkg::S_SCAN) && cmp.valid && !cmp.vis &&
                (!r_found || (sq_gap < r_best_d))) begin
                r_found  <= 1'b1;
                r_best   <= cmp.idx;
                r_best_d <= sq_gap;
                r_best_x <= cmp.x;
                r_best_y <= cmp.y;
            end
            if ((r_state == nnc_pkg::S_FIN) && !r_pend) begin
                r_pend      <= 1'b1;
                r_res_idx   <= r_best;
                r_res_start <= (r_best_d > nnc_pkg::DIST_W'(r_thr2));
                r_res_last  <= (r_emitted + NW'(1) == r_count);
                r_res_none  <= 1'b0;
                r_emitted   <= r_emitted + NW'(1);
                r_cur_x     <= r_best_x;
                r_cur_y     <= r_best_y;
            end
            // The pending result moves to the output register once that is free.
            if (r_pend && out_free) begin
                r_pend      <= 1'b0;
                r_out_valid <= 1'b1;
                r_out_idx   <= nnc_pkg::OUT_IDX_W'(r_res_idx);
                r_out_start <= r_res_start;
                r_out_last  <= r_res_last;
                r_out_none  <= r_res_none;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Point zero is kept aside so that the first step needs no memory read.
    always_ff @(posedge i_clk) begin
        if (load_we && (load_addr == '0)) begin
            r_p0_x <= i_point_x;
            r_p0_y <= i_point_y;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_point_index  = r_out_idx;
    assign o_object_start = r_out_start;
    assign o_chain_last   = r_out_last;
    assign o_no_point     = r_out_none;

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stepping |-> (r_emitted <= r_count))
        else $error("more points emitted than stored");
    a_tag_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmp.valid |-> (r_state == nnc_pkg::S_SCAN))
        else $error("scan tag outside the scan");
    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_none) |-> (!r_out_start && !r_out_last))
        else $error("empty result carries flags");
    a_fin_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nnc_pkg::S_FIN) |-> (r_found && (NW'(r_best) < r_count)))
        else $error("scan ended without a candidate");
endmodule

### sim/nnc_checker.sv
// Checker that predicts and compares the chained point stream of the clustering block.
`timescale 1ns / 1ps
module nnc_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_stall,
    input  logic                                  i_action,
    input  logic signed [nnc_pkg::COORD_BITS-1:0] i_point_x,
    input  logic signed [nnc_pkg::COORD_BITS-1:0] i_point_y,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic [nnc_pkg::OUT_IDX_W-1:0]         i_point_index,
    input  logic                                  i_object_start,
    input  logic                                  i_chain_last,
    input  logic                                  i_no_point,
    input  logic                                  i_cfg_we,
    input  logic [nnc_pkg::THR_W-1:0]             i_cfg_data,
    output int                                    o_pending,
    output int                                    o_errors
);
    typedef struct {
        logic [nnc_pkg::OUT_IDX_W-1:0] idx;
        logic                          start;
        logic                          last;
        logic                          none;
    } t_chain_point;

    logic signed [nnc_pkg::COORD_BITS-1:0] x_mem [nnc_pkg::MAX_POINTS];
    logic signed [nnc_pkg::COORD_BITS-1:0] y_mem [nnc_pkg::MAX_POINTS];
    bit                                    seen [nnc_pkg::MAX_POINTS];
    int                                    n_points;
    int                                    cur_idx;
    int                                    n_emitted;
    bit                                    stepping;
    logic [nnc_pkg::THR_W-1:0]             threshold;
    t_chain_point                          expected_points [$];

    function automatic longint gap_sq(int a, int b);
        longint dx;
        longint dy;
        dx = longint'(x_mem[a]) - longint'(x_mem[b]);
        dy = longint'(y_mem[a]) - longint'(y_mem[b]);
        return dx * dx + dy * dy;
    endfunction

    // Works out the chained point that one step should emit and updates the set.
    task automatic predict_step();
        t_chain_point r;
        int           best;
        longint       best_d;
        longint       d;
        bit           found;
        longint       thr2;
        best   = 0;
        best_d = 0;
        found  = 0;
        r      = '{idx: '0, start: 1'b0, last: 1'b0, none: 1'b0};
        if (!stepping) begin
            stepping  = 1;
            n_emitted = 0;
            foreach (seen[i]) seen[i] = 0;
        end
        if (n_emitted >= n_points) begin
            r.none = 1'b1;
        end else begin
            if (n_emitted == 0) begin
                r.start = 1'b1;
            end else begin
                for (int i = 0; i < n_points; i++) begin
                    if (!seen[i]) begin
                        d = gap_sq(cur_idx, i);
                        if (!found || d < best_d) begin
                            found  = 1;
                            best   = i;
                            best_d = d;
                        end
                    end
                end
                thr2    = longint'(threshold) * longint'(threshold);
                r.start = best_d > thr2;
            end
            seen[best] = 1;
            cur_idx    = best;
            n_emitted++;
            r.idx  = nnc_pkg::OUT_IDX_W'(best);
            r.last = n_emitted == n_points;
        end
        expected_points.insert(expected_points.size(), r);
    endtask

    always @(posedge i_clk) begin
        t_chain_point e;
        if (!i_rst_n) begin
            n_points  = 0;
            cur_idx   = 0;
            n_emitted = 0;
            stepping  = 0;
            threshold = nnc_pkg::THR_RESET;
            foreach (seen[i]) seen[i] = 0;
            expected_points.delete();
        end else begin
            if (i_cfg_we)
                threshold = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                if (i_action == nnc_pkg::ACT_LOAD) begin
                    if (stepping) begin
                        stepping = 0;
                        n_points = 0;
                    end
                    if (n_points < nnc_pkg::MAX_POINTS) begin
                        x_mem[n_points] = i_point_x;
                        y_mem[n_points] = i_point_y;
                        n_points++;
                    end
                end else begin
                    predict_step();
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result idx=%0d start=%0b last=%0b none=%0b",
                             $time, i_point_index, i_object_start, i_chain_last, i_no_point);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_points.pop_front();
                    if (e.idx !== i_point_index || e.start !== i_object_start ||
                        e.last !== i_chain_last || e.none !== i_no_point) begin
                        $display("%0t: mismatch expected idx=%0d start=%0b last=%0b none=%0b",
                                 $time, e.idx, e.start, e.last, e.none);
                        $display("%0t:          actual   idx=%0d start=%0b last=%0b none=%0b",
                                 $time, i_point_index, i_object_start, i_chain_last,
                                 i_no_point);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= expected_points.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end
endmodule

### sim/testbench.sv
// Top of the testbench: clock, reset, stimulus and verdict for the clustering block.
`timescale 1ns / 1ps
module testbench;
    localparam int   STALL_CAP  = 20000;
    localparam int   ITEM_GOAL  = 580;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_in_valid;
    logic                                  o_in_stall;
    logic                                  i_action;
    logic signed [nnc_pkg::COORD_BITS-1:0] i_point_x;
    logic signed [nnc_pkg::COORD_BITS-1:0] i_point_y;
    logic                                  o_out_valid;
    logic                                  i_out_stall;
    logic [nnc_pkg::OUT_IDX_W-1:0]         o_point_index;
    logic                                  o_object_start;
    logic                                  o_chain_last;
    logic                                  o_no_point;
    logic                                  i_cfg_we;
    logic [nnc_pkg::THR_W-1:0]             i_cfg_data;
    int                                    pending;
    int                                    errors;
    int                                    n_sent;
    int                                    quiet_cycles;
    bit                                    calm;

    nearest_neighbor_chain_cluster dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_point_index  (o_point_index),
        .o_object_start (o_object_start),
        .o_chain_last   (o_chain_last),
        .o_no_point     (o_no_point),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    nnc_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_point_index  (o_point_index),
        .i_object_start (o_object_start),
        .i_chain_last   (o_chain_last),
        .i_no_point     (o_no_point),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    always #5 i_clk = ~i_clk;

    // The watchdog only counts cycles in which neither channel completes a transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(logic act, logic signed [nnc_pkg::COORD_BITS-1:0] x,
                             logic signed [nnc_pkg::COORD_BITS-1:0] y);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_point_x  <= x;
        i_point_y  <= y;
        // Stall only moves at clock edges, so its mid-cycle value decides the next edge.
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        n_sent++;
    endtask

    task automatic set_threshold(logic [nnc_pkg::THR_W-1:0] value);
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_set(int n, bit clustered);
        int cx;
        int cy;
        cx = $urandom_range(0, 200000) - 100000;
        cy = $urandom_range(0, 200000) - 100000;
        for (int i = 0; i < n; i++) begin
            if (clustered) begin
                if ($urandom_range(0, 3) == 0) begin
                    cx = $urandom_range(0, 200000) - 100000;
                    cy = $urandom_range(0, 200000) - 100000;
                end
                send_item(nnc_pkg::ACT_LOAD,
                          nnc_pkg::COORD_BITS'(cx + $urandom_range(0, 800) - 400),
                          nnc_pkg::COORD_BITS'(cy + $urandom_range(0, 800) - 400));
            end else begin
                send_item(nnc_pkg::ACT_LOAD, nnc_pkg::COORD_BITS'($urandom),
                          nnc_pkg::COORD_BITS'($urandom));
            end
        end
    endtask

    task automatic run_steps(int n);
        repeat (n) send_item(nnc_pkg::ACT_STEP, nnc_pkg::COORD_BITS'($urandom),
                             nnc_pkg::COORD_BITS'($urandom));
    endtask

    initial begin
        int n;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_action     = nnc_pkg::ACT_LOAD;
        i_point_x    = '0;
        i_point_y    = '0;
        i_out_stall  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        n_sent       = 0;
        quiet_cycles = 0;
        calm         = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Steps on an empty set report that no point is left.
        run_steps(2);

        // Equal gaps around the first point must resolve to the lowest index.
        set_threshold('0);
        send_item(nnc_pkg::ACT_LOAD, 18'sd0, 18'sd0);
        send_item(nnc_pkg::ACT_LOAD, 18'sd5, 18'sd0);
        send_item(nnc_pkg::ACT_LOAD, -18'sd5, 18'sd0);
        send_item(nnc_pkg::ACT_LOAD, 18'sd0, 18'sd5);
        send_item(nnc_pkg::ACT_LOAD, 18'sd5, 18'sd0);
        run_steps(6);

        set_threshold(16'hFFFF);
        send_item(nnc_pkg::ACT_LOAD, -18'sd131072, -18'sd131072);
        send_item(nnc_pkg::ACT_LOAD, 18'sd131071, 18'sd131071);
        send_item(nnc_pkg::ACT_LOAD, 18'sd131071, -18'sd131072);
        send_item(nnc_pkg::ACT_LOAD, -18'sd131072, 18'sd131071);
        send_item(nnc_pkg::ACT_LOAD, 18'sd0, 18'sd0);
        run_steps(6);

        set_threshold(16'd500);

        while (n_sent < ITEM_GOAL) begin
            if (n_sent > ITEM_GOAL - 100)
                calm = 1;
            if (!calm) begin
                case ($urandom_range(0, 7))
                    0: set_threshold(nnc_pkg::THR_W'($urandom));
                    1: set_threshold(nnc_pkg::THR_W'($urandom_range(0, 700)));
                    default: ;
                endcase
            end
            n = $urandom_range(1, 14);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8))
                    send_item(logic'($urandom_range(0, 1)), nnc_pkg::COORD_BITS'($urandom),
                              nnc_pkg::COORD_BITS'($urandom));
            end else begin
                load_set(n, $urandom_range(0, 2) != 0);
                run_steps(n + $urandom_range(0, 2));
            end
        end

        i_in_valid <= 1'b0;
        n = 0;
        while (pending != 0 && n < STALL_CAP) begin
            @(negedge i_clk);
            n++;
        end
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
